[design/twdf_pkg.sv]
// Shared types, constants and helpers for the time window dedup filter.
// No dependencies; used by twdf_table and time_window_dedup_filter_top.
package twdf_pkg;

  // default sizes and reset values
  localparam int          TABLE_DEPTH_DEF = 16;
  localparam int          TIME_BITS_DEF   = 48;
  localparam int          KEY_BYTES       = 16;
  localparam int          KEY_BITS        = 8 * KEY_BYTES;
  localparam int          HALF_BITS       = KEY_BITS / 2;
  localparam int          WINDOW_BITS     = 32;
  localparam int          CFG_IDX_BITS    = 8;
  localparam int          CFG_DATA_BITS   = 32;
  localparam logic [31:0] RESET_WINDOW_MS = 32'd600000;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED   = 8'd1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_DONE
  } twdf_state_t;

  // cut the key at its first zero byte and fold a..z to upper case
  function automatic logic [KEY_BITS-1:0] normalize_key(input logic [KEY_BITS-1:0] raw);
    logic [KEY_BITS-1:0] res;
    logic                ended;
    logic [7:0]          b;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[KEY_BITS-1-8*i -: 8];
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        b = 8'h00;
      end
      if (b >= 8'h61 && b <= 8'h7a) begin
        b = b - 8'h20;
      end
      res[KEY_BITS-1-8*i -: 8] = b;
    end
    return res;
  endfunction

endpackage

[design/twdf_table.sv]
// Entry store for the dedup filter: key and timestamp arrays, one write
// and one registered read port. Depends on twdf_pkg for the key width.
module twdf_table #(
  parameter int DEPTH     = twdf_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS = twdf_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [twdf_pkg::KEY_BITS-1:0] wr_key,
  input  logic [TIME_BITS-1:0]          wr_stamp,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [twdf_pkg::KEY_BITS-1:0] rd_key,
  output logic [TIME_BITS-1:0]          rd_stamp
);

  logic [twdf_pkg::KEY_BITS-1:0] key_mem   [DEPTH];
  logic [TIME_BITS-1:0]          stamp_mem [DEPTH];
  logic [twdf_pkg::KEY_BITS-1:0] rd_key_r;
  logic [TIME_BITS-1:0]          rd_stamp_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r   <= key_mem[rd_addr];
      rd_stamp_r <= stamp_mem[rd_addr];
    end
  end

  assign rd_key   = rd_key_r;
  assign rd_stamp = rd_stamp_r;

endmodule

[design/time_window_dedup_filter_top.sv]
// Time window dedup filter top level: sequencer, entry ring and result beat.
// Depends on twdf_pkg and twdf_table.
//
// An item that is disabled, not listed or empty skips the walk and goes
// straight to the result stage. An item that meets an empty table goes
// straight to the append. Otherwise the single read port of the entry store
// walks every live entry once, and in that same walk one shared unit checks
// the entry's age against the window, writes survivors back in order and
// compares keys. A hit then goes to the result stage and a miss to the
// append first. The result stage waits while the output is stalled. The
// block takes one item at a time and is back in idle in the same cycle that
// the result is loaded. The next item may be taken while a finished result
// beat still waits at the output. Entries live in a ring addressed from the
// oldest, so evicting the oldest only moves the head. Config writes to a
// mapped index empty the table, and config writes are taken while no item
// is in work; a pending config write holds off the input.
module time_window_dedup_filter_top #(
  parameter int TABLE_DEPTH = twdf_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = twdf_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [twdf_pkg::HALF_BITS-1:0]     in_key_first_half,
  input  logic [twdf_pkg::HALF_BITS-1:0]     in_key_second_half,
  input  logic [TIME_BITS-1:0]               in_now_ms,
  input  logic                               in_listed,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_fire,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [twdf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [twdf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;

  twdf_pkg::twdf_state_t state_r, state_nxt;

  logic [twdf_pkg::KEY_BITS-1:0]    key_r, key_nxt;
  logic [TIME_BITS-1:0]             now_r, now_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [AW-1:0]                    head_r, head_nxt;
  logic [CW-1:0]                    i_r, i_nxt;
  logic [CW-1:0]                    w_r, w_nxt;
  logic                             rd_pend_r, rd_pend_nxt;
  logic                             hit_r, hit_nxt;
  logic                             fire_r, fire_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_fire_r, out_fire_nxt;
  logic [twdf_pkg::WINDOW_BITS-1:0] window_r, window_nxt;
  logic                             enabled_r, enabled_nxt;

  logic                             in_acc;
  logic                             cfg_acc;
  logic                             cfg_hit;
  logic                             out_free;
  logic                             scan_done;
  logic                             bypass;
  logic [twdf_pkg::KEY_BITS-1:0]    norm_key;

  // entry store hookup
  logic                             tbl_wr_en;
  logic [AW-1:0]                    tbl_wr_addr;
  logic [twdf_pkg::KEY_BITS-1:0]    tbl_wr_key;
  logic [TIME_BITS-1:0]             tbl_wr_stamp;
  logic                             tbl_rd_en;
  logic [AW-1:0]                    tbl_rd_addr;
  logic [twdf_pkg::KEY_BITS-1:0]    tbl_rd_key;
  logic [TIME_BITS-1:0]             tbl_rd_stamp;

  // ring addressing and shared age/key compare unit
  logic [SW-1:0]                    rd_sum;
  logic [SW-1:0]                    wr_sum;
  logic [SW-1:0]                    rd_phys;
  logic [SW-1:0]                    wr_phys;
  logic [TIME_BITS-1:0]             age;
  logic                             fresh;
  logic                             key_eq;
  logic [AW-1:0]                    head_inc;

  // handshakes, a config write goes ahead of a waiting item
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != twdf_pkg::ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == twdf_pkg::ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == twdf_pkg::CFG_WINDOW_MS ||
                                 cfg_index == twdf_pkg::CFG_ENABLED);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_fire  = out_fire_r;

  // key normalization at accept
  assign norm_key = twdf_pkg::normalize_key({in_key_first_half, in_key_second_half});
  assign bypass   = !enabled_r || !in_listed ||
                    (norm_key[twdf_pkg::KEY_BITS-1 -: 8] == 8'h00);

  assign scan_done = (i_r == count_r) && !rd_pend_r;

  // logical slot to physical slot: one compare and subtract
  assign rd_sum  = SW'(head_r) + SW'(i_r);
  assign wr_sum  = SW'(head_r) + SW'(w_r);
  assign rd_phys = (rd_sum >= SW'(TABLE_DEPTH)) ? rd_sum - SW'(TABLE_DEPTH) : rd_sum;
  assign wr_phys = (wr_sum >= SW'(TABLE_DEPTH)) ? wr_sum - SW'(TABLE_DEPTH) : wr_sum;
  assign head_inc = (head_r == AW'(TABLE_DEPTH - 1)) ? '0 : head_r + AW'(1);

  // signed age against the window, key match
  assign age    = now_r - tbl_rd_stamp;
  assign fresh  = age[TIME_BITS-1] ||
                  (age < TIME_BITS'(window_r));
  assign key_eq = (tbl_rd_key == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twdf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (bypass) begin
            state_nxt = twdf_pkg::ST_DONE;
          end else if (count_r == '0) begin
            state_nxt = twdf_pkg::ST_ADD;
          end else begin
            state_nxt = twdf_pkg::ST_SCAN;
          end
        end
      end
      twdf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = hit_r ? twdf_pkg::ST_DONE : twdf_pkg::ST_ADD;
        end
      end
      twdf_pkg::ST_ADD: begin
        state_nxt = twdf_pkg::ST_DONE;
      end
      twdf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = twdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = twdf_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and table control
  always_comb begin
    key_nxt       = key_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    rd_pend_nxt   = 1'b0;
    hit_nxt       = hit_r;
    fire_nxt      = fire_r;
    window_nxt    = window_r;
    enabled_nxt   = enabled_r;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = wr_phys[AW-1:0];
    tbl_wr_key    = tbl_rd_key;
    tbl_wr_stamp  = tbl_rd_stamp;
    tbl_rd_en     = 1'b0;
    tbl_rd_addr   = rd_phys[AW-1:0];
    case (state_r)
      twdf_pkg::ST_IDLE: begin
        if (in_acc) begin
          key_nxt  = norm_key;
          now_nxt  = in_now_ms;
          i_nxt    = '0;
          w_nxt    = '0;
          hit_nxt  = 1'b0;
          fire_nxt = 1'b0;
        end
      end
      twdf_pkg::ST_SCAN: begin
        // issue the next read
        if (i_r != count_r) begin
          tbl_rd_en   = 1'b1;
          i_nxt       = i_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
        // check the entry read last cycle, keep it in order if fresh
        if (rd_pend_r && fresh) begin
          tbl_wr_en = 1'b1;
          w_nxt     = w_r + CW'(1);
          if (key_eq) begin
            hit_nxt = 1'b1;
          end
        end
        if (scan_done) begin
          count_nxt = w_r;
        end
      end
      twdf_pkg::ST_ADD: begin
        // append; a full table overwrites the oldest and moves the head
        tbl_wr_en    = 1'b1;
        tbl_wr_key   = key_r;
        tbl_wr_stamp = now_r;
        fire_nxt     = 1'b1;
        if (w_r == CW'(TABLE_DEPTH)) begin
          head_nxt = head_inc;
        end else begin
          count_nxt = w_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
    // config writes empty the table
    if (cfg_hit) begin
      count_nxt = '0;
      head_nxt  = '0;
      if (cfg_index == twdf_pkg::CFG_WINDOW_MS) begin
        window_nxt = cfg_data[twdf_pkg::WINDOW_BITS-1:0];
      end else begin
        enabled_nxt = cfg_data[0];
      end
    end
  end

  // result beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_fire_nxt  = out_fire_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == twdf_pkg::ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_fire_nxt  = fire_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twdf_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      i_r         <= '0;
      w_r         <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      fire_r      <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= twdf_pkg::RESET_WINDOW_MS;
      enabled_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      i_r         <= i_nxt;
      w_r         <= w_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hit_r       <= hit_nxt;
      fire_r      <= fire_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    out_fire_r <= out_fire_nxt;
  end

  twdf_table #(
    .DEPTH     (TABLE_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_wr_addr),
    .wr_key   (tbl_wr_key),
    .wr_stamp (tbl_wr_stamp),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_key   (tbl_rd_key),
    .rd_stamp (tbl_rd_stamp)
  );

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // compaction write pointer never overtakes the read pointer
  a_w_behind_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twdf_pkg::ST_SCAN) |-> (w_r <= i_r))
    else $error("write pointer ahead of read pointer");

  // an append is always followed by the result stage
  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twdf_pkg::ST_ADD) |=> (state_r == twdf_pkg::ST_DONE))
    else $error("append not followed by result");

  // a config write leaves the table empty
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (count_r == '0))
    else $error("config write did not empty table");

  // a result beat with fire set comes only after an append
  a_fire_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twdf_pkg::ST_DONE && fire_r) |-> (w_r <= CW'(TABLE_DEPTH) && !hit_r))
    else $error("fire without append");

endmodule

[bench/tb_top.sv]
// Self-checking bench for time_window_dedup_filter_top: clocked driver and monitor,
// a built-in model of the dedup table, directed and random phases.
// Depends on twdf_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_top;

  localparam int KEY_W       = twdf_pkg::KEY_BITS;
  localparam int HALF_W      = twdf_pkg::HALF_BITS;
  localparam int TBITS       = twdf_pkg::TIME_BITS_DEF;
  localparam int DEPTH       = twdf_pkg::TABLE_DEPTH_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_BEATS = 65;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = DEPTH + 6;

  // register indexes outside the map, writes there must be ignored
  localparam logic [twdf_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [twdf_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TBITS-1:0] stamp;
  } seen_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TBITS-1:0] now;
    logic             listed;
    logic [3:0]       gap;
  } key_beat_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                               in_valid           = 1'b0;
  logic                               in_stall;
  logic [HALF_W-1:0]                  in_key_first_half  = '0;
  logic [HALF_W-1:0]                  in_key_second_half = '0;
  logic [TBITS-1:0]                   in_now_ms          = '0;
  logic                               in_listed          = 1'b0;
  logic                               out_valid;
  logic                               out_stall          = 1'b0;
  logic                               out_fire;
  logic                               cfg_valid          = 1'b0;
  logic                               cfg_ready;
  logic [twdf_pkg::CFG_IDX_BITS-1:0]  cfg_index          = '0;
  logic [twdf_pkg::CFG_DATA_BITS-1:0] cfg_data           = '0;

  // model state
  seen_entry_t      recent_keys[$];
  logic [31:0]      cfg_window = twdf_pkg::RESET_WINDOW_MS;
  logic             cfg_en     = 1'b0;

  key_beat_t        pending_beats[$];
  logic             fire_expected[$];

  // pacing controls set between phases
  bit               tx_idle  = 1'b1;
  bit               rx_idle  = 1'b1;
  bit               hold_arm = 1'b0;
  logic             hold_on  = 1'b0;

  int               tx_idle_cnt = 0;
  int               rx_wait     = 0;
  key_beat_t        nxt;
  logic             want_fire;
  int               mismatches  = 0;
  int               beats_in    = 0;
  int               results_out = 0;
  int               fires_out   = 0;
  int               reg_writes  = 0;

  time_window_dedup_filter_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_first_half  (in_key_first_half),
    .in_key_second_half (in_key_second_half),
    .in_now_ms          (in_now_ms),
    .in_listed          (in_listed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fire           (out_fire),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // truncate at the first NUL, upper-case letters only
  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic [7:0]       ch;
    bit               stop;
    res  = '0;
    stop = 1'b0;
    for (int n = 15; n >= 0; n--) begin
      ch = raw[n*8 +: 8];
      if (ch == 8'h00) stop = 1'b1;
      if (!stop) begin
        if (ch >= 8'h61 && ch <= 8'h7a) ch = ch ^ 8'h20;
        res[n*8 +: 8] = ch;
      end
    end
    return res;
  endfunction

  // expire, look up, then insert on a miss; returns the fire bit
  function automatic logic dedup_decide(input logic [KEY_W-1:0] raw,
                                        input logic [TBITS-1:0] now,
                                        input logic lst);
    logic [KEY_W-1:0] k;
    logic [TBITS-1:0] age;
    seen_entry_t      e;
    int               w;
    k = fold_key(raw);
    if (!cfg_en || !lst || k[KEY_W-1 -: 8] == 8'h00) return 1'b0;
    // drop stale entries, survivors keep their order
    w = 0;
    for (int n = 0; n < recent_keys.size(); n++) begin
      age = now - recent_keys[n].stamp;
      if (age[TBITS-1] || age < {{(TBITS-32){1'b0}}, cfg_window}) begin
        recent_keys[w] = recent_keys[n];
        w++;
      end
    end
    while (recent_keys.size() > w) recent_keys.delete(recent_keys.size() - 1);
    for (int n = 0; n < recent_keys.size(); n++)
      if (recent_keys[n].key == k) return 1'b0;
    // full table pushes out the oldest
    if (recent_keys.size() >= DEPTH) recent_keys.delete(0);
    e.key   = k;
    e.stamp = now;
    recent_keys.push_back(e);
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [7:0] idx, input logic [31:0] val);
    if (idx == twdf_pkg::CFG_WINDOW_MS) begin
      cfg_window = val;
      recent_keys.delete();
    end else if (idx == twdf_pkg::CFG_ENABLED) begin
      cfg_en = val[0];
      recent_keys.delete();
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        fire_expected.push_back(dedup_decide({in_key_first_half, in_key_second_half},
                                             in_now_ms, in_listed));
        beats_in++;
        tx_idle_cnt = 0;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && tx_idle_cnt >= pending_beats[0].gap) begin
          nxt = pending_beats.pop_front();
          in_valid           <= 1'b1;
          in_key_first_half  <= nxt.key[KEY_W-1 -: HALF_W];
          in_key_second_half <= nxt.key[HALF_W-1:0];
          in_now_ms          <= nxt.now;
          in_listed          <= nxt.listed;
        end else begin
          in_valid <= 1'b0;
          tx_idle_cnt++;
        end
      end
    end
  end

  // result monitor and stall generation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (out_fire) fires_out++;
        if (fire_expected.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got fire=%0b",
                   $time, out_fire);
          mismatches++;
        end else begin
          want_fire = fire_expected.pop_front();
          if (out_fire !== want_fire) begin
            $display("%0t: fire mismatch, expected %0b, got %0b", $time, want_fire, out_fire);
            mismatches++;
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= hold_on || (rx_wait != 0);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // stimulus helpers
  function automatic void queue_key(input logic [KEY_W-1:0] k, input logic [TBITS-1:0] t,
                                    input logic lst);
    key_beat_t b;
    b.key    = k;
    b.now    = t;
    b.listed = lst;
    b.gap    = tx_idle ? 4'($urandom_range(0, 10)) : 4'd0;
    pending_beats.push_back(b);
  endfunction

  function automatic logic [KEY_W-1:0] str_key(input string s);
    logic [KEY_W-1:0] res;
    res = '0;
    for (int n = 0; n < s.len() && n < 16; n++) res[KEY_W-1-8*n -: 8] = s[n];
    return res;
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] ch;
    if ($urandom_range(0, 1)) begin
      ch = 8'($urandom_range(8'h61, 8'h7a));
      if ($urandom_range(0, 1)) ch = ch ^ 8'h20;
    end else begin
      ch = 8'($urandom_range(1, 255));
    end
    return ch;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key(input int len);
    logic [KEY_W-1:0] res;
    res = '0;
    for (int n = 0; n < len; n++) res[KEY_W-1-8*n -: 8] = rand_char();
    return res;
  endfunction

  // flip letter case at random and maybe put junk after the terminator
  function automatic logic [KEY_W-1:0] vary_key(input logic [KEY_W-1:0] k, input int len);
    logic [KEY_W-1:0] res;
    logic [7:0]       ch;
    bit               junk;
    res  = k;
    junk = ($urandom_range(0, 1) != 0);
    for (int n = 0; n < 16; n++) begin
      ch = res[KEY_W-1-8*n -: 8];
      if (n < len) begin
        if ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7a && $urandom_range(0, 1))
          ch = ch ^ 8'h20;
      end else if (n > len && junk) begin
        ch = 8'($urandom_range(0, 255));
      end
      res[KEY_W-1-8*n -: 8] = ch;
    end
    return res;
  endfunction

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || fire_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, val);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // enable bit with random upper data bits
  task automatic write_enable(input logic en);
    write_reg(twdf_pkg::CFG_ENABLED, ($urandom & 32'hFFFF_FFFE) | {31'b0, en});
  endtask

  // pool of keys reused with case and junk changes so hits and evictions happen
  task automatic random_phase(input logic [TBITS-1:0] t0, input int unsigned step_max);
    logic [KEY_W-1:0] pool [POOL_SIZE];
    int               pool_len [POOL_SIZE];
    logic [KEY_W-1:0] k;
    logic [TBITS-1:0] t;
    int               pick;
    int               roll;
    for (int n = 0; n < POOL_SIZE; n++) begin
      pool_len[n] = $urandom_range(1, 16);
      pool[n]     = rand_key(pool_len[n]);
    end
    t = t0;
    for (int n = 0; n < PHASE_BEATS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 9) begin
        k = {$urandom, $urandom, $urandom, $urandom};
        if (roll < 4) k[KEY_W-1 -: 8] = 8'h00;
      end else begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        k    = vary_key(pool[pick], pool_len[pick]);
      end
      if ($urandom_range(0, 9) == 0) t = t - $urandom_range(0, step_max);
      else t = t + $urandom_range(0, step_max);
      queue_key(k, t, $urandom_range(0, 9) != 0);
    end
    drain();
  endtask

  function automatic logic [TBITS-1:0] rand_time();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom};
  endfunction

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings leave the filter disabled
    queue_key(str_key("ALPHA"), 48'd1000, 1'b1);
    queue_key(str_key("ALPHA"), 48'd1001, 1'b1);
    drain();
    write_enable(1'b1);

    // directed corners under the default window
    queue_key(str_key("ALPHA"), 48'd1000, 1'b1);
    queue_key(str_key("alpha"), 48'd1002, 1'b1);
    queue_key(str_key("AlPhA") | {48'h0, 80'h7a41_7a7a_4142_6364_7a7a}, 48'd1003, 1'b1);
    queue_key(str_key("BRAVO"), 48'd1004, 1'b0);
    queue_key('0, 48'd1005, 1'b1);
    queue_key({8'h00, {15{8'hA5}}}, 48'd1006, 1'b1);
    queue_key({16{8'hFF}}, 48'd1007, 1'b1);
    queue_key({16{8'hFF}}, 48'd1008, 1'b1);
    queue_key(str_key("abcdefghijklmnop"), 48'd1009, 1'b1);
    queue_key(str_key("ABCDEFGHIJKLMNOP"), 48'd1010, 1'b1);
    // bytes next to the letter ranges are not folded
    queue_key({8'h60, 8'h7B, 112'h0}, 48'd1011, 1'b1);
    queue_key({8'h40, 8'h5B, 112'h0}, 48'd1012, 1'b1);
    // one below the window, then exactly at it
    queue_key(str_key("ALPHA"), 48'd600999, 1'b1);
    queue_key(str_key("ALPHA"), 48'd601000, 1'b1);
    // clock running backwards keeps the entry
    queue_key(str_key("CHARLIE"), 48'd700000, 1'b1);
    queue_key(str_key("charlie"), 48'd650000, 1'b1);
    // time counter wrap
    queue_key(str_key("DELTA"), {TBITS{1'b1}}, 1'b1);
    queue_key(str_key("delta"), 48'd5, 1'b1);
    drain();

    // unmapped indexes leave the table alone
    write_reg(CFG_UNUSED_LO, $urandom);
    write_reg(CFG_UNUSED_HI, $urandom);
    queue_key(str_key("Delta"), 48'd6, 1'b1);
    drain();

    // zero window: every listed key fires
    write_reg(twdf_pkg::CFG_WINDOW_MS, 32'd0);
    queue_key(str_key("ECHO"), 48'd10, 1'b1);
    queue_key(str_key("echo"), 48'd10, 1'b1);
    drain();

    // random phases over a spread of settings and pacing
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          tx_idle = 1'b1; rx_idle = 1'b1;
          write_reg(twdf_pkg::CFG_WINDOW_MS, 32'd1000);
          write_enable(1'b1);
          random_phase(rand_time(), 150);
        end
        1: begin
          tx_idle = 1'b0; rx_idle = 1'b0;
          write_reg(twdf_pkg::CFG_WINDOW_MS, 32'd0);
          write_enable(1'b1);
          random_phase(rand_time(), 50);
        end
        2: begin
          // back-to-back offers against a long output hold
          tx_idle = 1'b0; rx_idle = 1'b0;
          write_reg(twdf_pkg::CFG_WINDOW_MS, 32'hFFFF_FFFF);
          write_enable(1'b1);
          hold_arm = 1'b1;
          random_phase(rand_time(), 100000);
        end
        3: begin
          tx_idle = 1'b1; rx_idle = 1'b1;
          write_reg(twdf_pkg::CFG_WINDOW_MS, $urandom);
          write_enable(1'b1);
          random_phase(rand_time(), 2000000);
        end
        4: begin
          write_reg(twdf_pkg::CFG_WINDOW_MS, 32'd500);
          write_enable(1'b0);
          random_phase(rand_time(), 60);
        end
        5: begin
          tx_idle = 1'b1; rx_idle = 1'b0;
          write_reg(twdf_pkg::CFG_WINDOW_MS, $urandom_range(100, 5000));
          write_enable(1'b1);
          random_phase(rand_time(), 400);
        end
        6: begin
          tx_idle = 1'b0; rx_idle = 1'b1;
          write_reg(twdf_pkg::CFG_WINDOW_MS, $urandom_range(1, 64));
          write_enable(1'b1);
          random_phase(rand_time(), 12);
        end
        default: begin
          tx_idle = 1'b1; rx_idle = 1'b1;
          write_reg(twdf_pkg::CFG_WINDOW_MS, twdf_pkg::RESET_WINDOW_MS);
          write_enable(1'b1);
          random_phase(48'hFFFF_FFD0_0000, 90000);
        end
      endcase
    end

    $display("tb_top: %0d key beats taken, %0d result beats checked, %0d alerts fired",
             beats_in, results_out, fires_out);
    $display("tb_top: %0d register writes across windows 0..max, enable on/off, wrap",
             reg_writes);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb_top: timeout with %0d results still expected", fire_expected.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
